>>> rtl/y2r_pkg.sv
// ----------------------------------------------------------------------------
// y2r_pkg
// Shared constants, coefficient helper and types for the YUYV to RGB converter.
// ----------------------------------------------------------------------------
`default_nettype none

package y2r_pkg;

    // Fraction bits of the fixed-point color coefficients.
    localparam int COEF_FRAC_BITS = 16;

    // Coefficient width: one integer bit, since every coefficient is below 2.
    localparam int COEF_W = COEF_FRAC_BITS + 1;

    // Width of the signed products and sums.
    // The magnitude stays below 2^10 * 2^F, so F + 12 bits leaves margin.
    localparam int SUM_W = COEF_FRAC_BITS + 12;

    localparam int PIX_W  = 8;
    localparam int GAIN_W = 9;
    localparam int CHR_W  = PIX_W + 1;

    // Coefficients in millionths.
    localparam longint unsigned MILLI_RV = 64'd1370705;
    localparam longint unsigned MILLI_GV = 64'd698001;
    localparam longint unsigned MILLI_GU = 64'd337633;
    localparam longint unsigned MILLI_BU = 64'd1732446;

    localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(220);
    localparam logic [PIX_W-1:0]  PIX_MAX    = '1;
    localparam logic [PIX_W-1:0]  CHR_OFFSET = PIX_W'(128);

    // Round a coefficient given in millionths to fixed point.
    function automatic logic [COEF_W-1:0] fixed_coef(input longint unsigned millionths);
        longint unsigned scaled;
        scaled = millionths << COEF_FRAC_BITS;
        return COEF_W'((scaled + 64'd500000) / 64'd1000000);
    endfunction

    localparam logic [COEF_W-1:0] COEF_RV = fixed_coef(MILLI_RV);
    localparam logic [COEF_W-1:0] COEF_GV = fixed_coef(MILLI_GV);
    localparam logic [COEF_W-1:0] COEF_GU = fixed_coef(MILLI_GU);
    localparam logic [COEF_W-1:0] COEF_BU = fixed_coef(MILLI_BU);

    // Chroma products shared by both pixel lanes.
    typedef struct packed {
        logic signed [SUM_W-1:0] rv;
        logic signed [SUM_W-1:0] gv;
        logic signed [SUM_W-1:0] gu;
        logic signed [SUM_W-1:0] bu;
    } y2r_prod_t;

    // Stage load enables from the pipeline control.
    typedef struct packed {
        logic en_mul;
        logic en_sum;
        logic en_out;
    } y2r_ctl_t;

    // One RGB pixel.
    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
    } y2r_rgb_t;

endpackage

`default_nettype wire

>>> rtl/yuyv_to_rgb_converter.sv
// ----------------------------------------------------------------------------
// yuyv_to_rgb_converter
// Converts one YUYV 4:2:2 word into two RGB888 pixels with an output gain.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake            Word contents
//   s_       in         s_valid / s_ready    Y0, U, Y1, V, end flag
//   m_       out        m_valid / m_ready    RGB first, RGB second, end flag
//   cfg_     in         cfg_wr_en            output gain (9 bits)
//
// Three stages: chroma multiply, sum and clamp, gain. A word passes the product,
// clamp and scale registers in turn; one word is taken every cycle while the
// output is drained. Each stage loads when it is empty or the next one moves,
// so a stalled output register holds only itself back until the rest fills.
// Reset is synchronous, active low, and empties every stage; the gain
// returns to 220.
// ----------------------------------------------------------------------------
`default_nettype none

module yuyv_to_rgb_converter (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,

    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [y2r_pkg::PIX_W-1:0]     s_luma_first,
    input  wire logic [y2r_pkg::PIX_W-1:0]     s_chroma_blue,
    input  wire logic [y2r_pkg::PIX_W-1:0]     s_luma_second,
    input  wire logic [y2r_pkg::PIX_W-1:0]     s_chroma_red,
    input  wire logic                          s_end_in,

    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [y2r_pkg::PIX_W-1:0]          m_red_first,
    output logic [y2r_pkg::PIX_W-1:0]          m_green_first,
    output logic [y2r_pkg::PIX_W-1:0]          m_blue_first,
    output logic [y2r_pkg::PIX_W-1:0]          m_red_second,
    output logic [y2r_pkg::PIX_W-1:0]          m_green_second,
    output logic [y2r_pkg::PIX_W-1:0]          m_blue_second,
    output logic                               m_end_out,

    input  wire logic                          cfg_wr_en,
    input  wire logic [y2r_pkg::GAIN_W-1:0]    cfg_wr_data
);

    logic [y2r_pkg::GAIN_W-1:0] gain_reg;
    logic mul_valid_reg;
    logic sum_valid_reg;
    logic out_valid_reg;
    logic [2:0] end_reg;
    y2r_pkg::y2r_ctl_t ctl;
    y2r_pkg::y2r_prod_t prod;
    y2r_pkg::y2r_rgb_t rgb_first;
    y2r_pkg::y2r_rgb_t rgb_second;

    // Stage enables: a stage loads when it is empty or its word moves on.
    always_comb begin
        ctl.en_out = !out_valid_reg || m_ready;
        ctl.en_sum = !sum_valid_reg || ctl.en_out;
        ctl.en_mul = !mul_valid_reg || ctl.en_sum;
    end

    assign s_ready = ctl.en_mul;

    // Gain register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg <= y2r_pkg::GAIN_RESET;
        end else if (cfg_wr_en) begin
            gain_reg <= cfg_wr_data;
        end
    end

    // Stage valid bits.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mul_valid_reg <= 1'b0;
            sum_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (ctl.en_mul) begin
                mul_valid_reg <= s_valid;
            end
            if (ctl.en_sum) begin
                sum_valid_reg <= mul_valid_reg;
            end
            if (ctl.en_out) begin
                out_valid_reg <= sum_valid_reg;
            end
        end
    end

    // End flag rides along with the word.
    always_ff @(posedge aclk) begin
        if (ctl.en_mul) begin
            end_reg[0] <= s_end_in;
        end
        if (ctl.en_sum) begin
            end_reg[1] <= end_reg[0];
        end
        if (ctl.en_out) begin
            end_reg[2] <= end_reg[1];
        end
    end

    y2r_chroma u_chroma (
        .aclk        (aclk),
        .ctl         (ctl),
        .chroma_blue (s_chroma_blue),
        .chroma_red  (s_chroma_red),
        .prod        (prod)
    );

    y2r_lane u_lane_first (
        .aclk (aclk),
        .ctl  (ctl),
        .luma (s_luma_first),
        .prod (prod),
        .gain (gain_reg),
        .rgb  (rgb_first)
    );

    y2r_lane u_lane_second (
        .aclk (aclk),
        .ctl  (ctl),
        .luma (s_luma_second),
        .prod (prod),
        .gain (gain_reg),
        .rgb  (rgb_second)
    );

    // Merge both lanes into the output word.
    assign m_valid        = out_valid_reg;
    assign m_red_first    = rgb_first.red;
    assign m_green_first  = rgb_first.green;
    assign m_blue_first   = rgb_first.blue;
    assign m_red_second   = rgb_second.red;
    assign m_green_second = rgb_second.green;
    assign m_blue_second  = rgb_second.blue;
    assign m_end_out      = end_reg[2];

    // The input only stalls when every stage holds a word.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (mul_valid_reg && sum_valid_reg && out_valid_reg))
        else $error("input stalled with an empty stage");

    // A full middle stage that cannot move keeps its word.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (sum_valid_reg && !ctl.en_sum) |=> sum_valid_reg)
        else $error("middle stage lost a word while stalled");

    // Reset empties the pipeline.
    assert property (@(posedge aclk)
        !aresetn |=> (!mul_valid_reg && !sum_valid_reg && !out_valid_reg))
        else $error("pipeline not empty after reset");

endmodule

`default_nettype wire

>>> rtl/y2r_chroma.sv
// ----------------------------------------------------------------------------
// y2r_chroma
// Removes the chroma offset and forms the four registered chroma products.
// ----------------------------------------------------------------------------
`default_nettype none

module y2r_chroma (
    input  wire logic                          aclk,
    input  wire y2r_pkg::y2r_ctl_t             ctl,
    input  wire logic [y2r_pkg::PIX_W-1:0]     chroma_blue,
    input  wire logic [y2r_pkg::PIX_W-1:0]     chroma_red,
    output y2r_pkg::y2r_prod_t                 prod
);

    logic signed [y2r_pkg::CHR_W-1:0] du;
    logic signed [y2r_pkg::CHR_W-1:0] dv;
    y2r_pkg::y2r_prod_t prod_reg;
    y2r_pkg::y2r_prod_t prod_next;

    // Signed chroma differences around the midpoint.
    assign du = $signed({1'b0, chroma_blue}) - $signed({1'b0, y2r_pkg::CHR_OFFSET});
    assign dv = $signed({1'b0, chroma_red}) - $signed({1'b0, y2r_pkg::CHR_OFFSET});

    // One small multiplier per coefficient.
    always_comb begin
        prod_next.rv = $signed({1'b0, y2r_pkg::COEF_RV}) * dv;
        prod_next.gv = $signed({1'b0, y2r_pkg::COEF_GV}) * dv;
        prod_next.gu = $signed({1'b0, y2r_pkg::COEF_GU}) * du;
        prod_next.bu = $signed({1'b0, y2r_pkg::COEF_BU}) * du;
    end

    // Product register.
    always_ff @(posedge aclk) begin
        if (ctl.en_mul) begin
            prod_reg <= prod_next;
        end
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

>>> rtl/y2r_lane.sv
// ----------------------------------------------------------------------------
// y2r_lane
// One pixel lane: sums luma with the chroma products, clamps, applies gain.
// ----------------------------------------------------------------------------
`default_nettype none

module y2r_lane (
    input  wire logic                          aclk,
    input  wire y2r_pkg::y2r_ctl_t             ctl,
    input  wire logic [y2r_pkg::PIX_W-1:0]     luma,
    input  wire y2r_pkg::y2r_prod_t            prod,
    input  wire logic [y2r_pkg::GAIN_W-1:0]    gain,
    output y2r_pkg::y2r_rgb_t                  rgb
);

    localparam int F       = y2r_pkg::COEF_FRAC_BITS;
    localparam int INT_W   = y2r_pkg::SUM_W - F;
    localparam int SCL_W   = y2r_pkg::PIX_W + y2r_pkg::GAIN_W;
    localparam int SHR_W   = SCL_W - 8;

    logic [y2r_pkg::PIX_W-1:0] luma_reg;
    logic signed [y2r_pkg::SUM_W-1:0] base;
    logic signed [y2r_pkg::SUM_W-1:0] sum_r;
    logic signed [y2r_pkg::SUM_W-1:0] sum_g;
    logic signed [y2r_pkg::SUM_W-1:0] sum_b;
    y2r_pkg::y2r_rgb_t clamp_reg;
    y2r_pkg::y2r_rgb_t clamp_next;
    y2r_pkg::y2r_rgb_t scale_reg;
    y2r_pkg::y2r_rgb_t scale_next;

    // Truncate toward zero and clamp to the pixel range.
    function automatic logic [y2r_pkg::PIX_W-1:0] clamp_sum(
        input logic signed [y2r_pkg::SUM_W-1:0] s
    );
        logic [INT_W-2:0] whole;
        whole = s[y2r_pkg::SUM_W-2:F];
        if (s[y2r_pkg::SUM_W-1]) begin
            return '0;
        end else if (whole > (INT_W-1)'(y2r_pkg::PIX_MAX)) begin
            return y2r_pkg::PIX_MAX;
        end
        return whole[y2r_pkg::PIX_W-1:0];
    endfunction

    // Multiply by the gain, drop eight bits, saturate.
    function automatic logic [y2r_pkg::PIX_W-1:0] scale_chan(
        input logic [y2r_pkg::PIX_W-1:0]  c,
        input logic [y2r_pkg::GAIN_W-1:0] g
    );
        logic [SCL_W-1:0] p;
        logic [SHR_W-1:0] q;
        p = SCL_W'(c) * SCL_W'(g);
        q = p[SCL_W-1:8];
        if (q > SHR_W'(y2r_pkg::PIX_MAX)) begin
            return y2r_pkg::PIX_MAX;
        end
        return q[y2r_pkg::PIX_W-1:0];
    endfunction

    // Luma waits one stage to line up with the chroma products.
    always_ff @(posedge aclk) begin
        if (ctl.en_mul) begin
            luma_reg <= luma;
        end
    end

    // Channel sums with the luma scaled to the coefficient fraction.
    always_comb begin
        base  = $signed({{(INT_W - y2r_pkg::PIX_W){1'b0}}, luma_reg, {F{1'b0}}});
        sum_r = base + prod.rv;
        sum_g = base - prod.gv - prod.gu;
        sum_b = base + prod.bu;
        clamp_next.red   = clamp_sum(sum_r);
        clamp_next.green = clamp_sum(sum_g);
        clamp_next.blue  = clamp_sum(sum_b);
    end

    always_ff @(posedge aclk) begin
        if (ctl.en_sum) begin
            clamp_reg <= clamp_next;
        end
    end

    // Output gain.
    always_comb begin
        scale_next.red   = scale_chan(clamp_reg.red, gain);
        scale_next.green = scale_chan(clamp_reg.green, gain);
        scale_next.blue  = scale_chan(clamp_reg.blue, gain);
    end

    always_ff @(posedge aclk) begin
        if (ctl.en_out) begin
            scale_reg <= scale_next;
        end
    end

    assign rgb = scale_reg;

endmodule

`default_nettype wire
